// ===== hdl/led_matrix_framebuffer_flush_top_macros.svh =====
// Assertion macros for the LED matrix frame store.
// Uses the clock and reset names of the module that includes it.
`ifndef LED_MATRIX_FRAMEBUFFER_FLUSH_TOP_MACROS_SVH
`define LED_MATRIX_FRAMEBUFFER_FLUSH_TOP_MACROS_SVH

// same-cycle implication
`define LMFB_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LMFB_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/lmfb_pkg.sv =====
// Shared codes, constants and the queue entry type of the LED matrix frame store.
// No dependencies.
package lmfb_pkg;

   localparam int DEFAULT_MAX_DEVICES = 8;
   localparam int PIX_PER_ROW = 8;
   localparam int OFF_W = 12;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 7;

   localparam logic [2:0] PIX_MSB = 3'd7;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_ACROSS    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DOWN      = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROTATE    = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HIDDEN    = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CLIP_LEFT = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CLIP_COLS = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CLIP_TOP  = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_CLIP_ROWS = 4'd7;

   localparam logic [3:0] RESET_ACROSS = 4'd4;
   localparam logic [3:0] RESET_DOWN   = 4'd1;

   typedef struct packed {
      logic [1:0] op;
      logic       hidden;
      logic       hit;
      logic       with_flush;
      logic       value;
      logic [2:0] bit_sel;
   } lmfb_entry_type;

endpackage

// ===== hdl/lmfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lmfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              write_en,
   input  logic [ADDR_W-1:0] write_addr,
   input  logic [WIDTH-1:0]  write_data,
   input  logic              read_en,
   input  logic [ADDR_W-1:0] read_addr,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== hdl/lmfb_front.sv =====
// Front end: configuration registers, item intake, clipping and row folding.
// Depends on lmfb_pkg.
module lmfb_front #(
   parameter int MAX_DEVICES = lmfb_pkg::DEFAULT_MAX_DEVICES,
   localparam int ROW_W = $clog2(MAX_DEVICES * lmfb_pkg::PIX_PER_ROW),
   localparam int DEV_W = $clog2(MAX_DEVICES + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [lmfb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lmfb_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_kind,
   input  logic [6:0]                           req_pos_x,
   input  logic [6:0]                           req_pos_y,
   input  logic                                 req_pixel_on,
   input  logic                                 req_read_hidden,
   input  logic                                 q_full,
   output logic                                 q_push,
   output lmfb_pkg::lmfb_entry_type             q_entry,
   output logic [ROW_W-1:0]                     q_row,
   output logic [DEV_W-1:0]                     active_devices
);
   import lmfb_pkg::*;

   logic [3:0] across_ff, down_ff;
   logic       rotate_ff, hidden_ff;
   logic [6:0] clip_left_ff, clip_cols_ff, clip_top_ff, clip_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         across_ff    <= RESET_ACROSS;
         down_ff      <= RESET_DOWN;
         rotate_ff    <= 1'b0;
         hidden_ff    <= 1'b0;
         clip_left_ff <= '0;
         clip_cols_ff <= '0;
         clip_top_ff  <= '0;
         clip_rows_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_ACROSS:    across_ff    <= csr_data[3:0];
            REG_DOWN:      down_ff      <= csr_data[3:0];
            REG_ROTATE:    rotate_ff    <= csr_data[0];
            REG_HIDDEN:    hidden_ff    <= csr_data[0];
            REG_CLIP_LEFT: clip_left_ff <= csr_data;
            REG_CLIP_COLS: clip_cols_ff <= csr_data;
            REG_CLIP_TOP:  clip_top_ff  <= csr_data;
            REG_CLIP_ROWS: clip_rows_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [6:0]       scr_w, scr_h, xm1, ym1;
   logic [7:0]       dev_product, clip_x_end, clip_y_end;
   logic [DEV_W-1:0] m;
   logic [3:0]       band;
   logic [2:0]       yrow;
   logic [OFF_W-1:0] fold, stride_part, offset, store_size;
   logic             on_screen, in_store, hit, clip_ok, keep;

   assign scr_w = {across_ff, 3'b000};
   assign scr_h = {down_ff, 3'b000};
   assign dev_product = 8'(across_ff) * 8'(down_ff);

   always_comb begin
      if (dev_product == 8'd0 || dev_product > 8'(MAX_DEVICES)) begin
         m = DEV_W'(MAX_DEVICES);
      end else begin
         m = dev_product[DEV_W-1:0];
      end
   end

   assign on_screen = (req_pos_x != 7'd0) && (req_pos_y != 7'd0) &&
                      (req_pos_x <= scr_w) && (req_pos_y <= scr_h);

   // zero-based logical position after optional rotation
   assign xm1 = rotate_ff ? (scr_w - req_pos_x) : (req_pos_x - 7'd1);
   assign ym1 = rotate_ff ? (scr_h - req_pos_y) : (req_pos_y - 7'd1);

   assign band        = ym1[6:3];
   assign yrow        = ym1[2:0];
   assign fold        = OFF_W'(band) * OFF_W'(scr_w);
   assign stride_part = (OFF_W'(yrow) * OFF_W'(m)) << 3;
   assign offset      = stride_part + fold + OFF_W'(xm1);
   assign store_size  = OFF_W'(m) << 6;
   assign in_store    = offset < store_size;
   assign hit         = on_screen && in_store;

   assign clip_x_end = 8'(clip_left_ff) + 8'(clip_cols_ff);
   assign clip_y_end = 8'(clip_top_ff) + 8'(clip_rows_ff);
   assign clip_ok = (clip_left_ff == 7'd0) ||
                    ((req_pos_x >= clip_left_ff) && (8'(req_pos_x) < clip_x_end) &&
                     (req_pos_y >= clip_top_ff) && (8'(req_pos_y) < clip_y_end));

   always_comb begin
      case (req_kind)
         KIND_WRITE: keep = clip_ok && hit;
         KIND_READ:  keep = 1'b1;
         KIND_FLUSH: keep = !hidden_ff;
         KIND_CLEAR: keep = 1'b1;
         default:    keep = 1'b1;
      endcase
   end

   always_comb begin
      q_entry.op         = req_kind;
      q_entry.hidden     = (req_kind == KIND_READ) ? req_read_hidden : hidden_ff;
      q_entry.hit        = hit;
      q_entry.with_flush = !hidden_ff;
      q_entry.value      = req_pixel_on;
      q_entry.bit_sel    = offset[2:0];
   end

   assign q_row          = offset[3 +: ROW_W];
   assign q_push         = req_valid && !q_full && keep;
   assign req_stall      = q_full;
   assign active_devices = m;

endmodule

// ===== hdl/lmfb_queue.sv =====
// Two-entry queue between the front end and the back end.
// No dependencies.
module lmfb_queue #(
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output logic [DATA_W-1:0] head
);

   logic [1:0]        count_ff, count_in;
   logic [DATA_W-1:0] slot0_ff, slot0_in, slot1_ff, slot1_in;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         if (count_ff == 2'd0 || (count_ff == 2'd1 && pop)) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
      end
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot0_ff;

endmodule

// ===== hdl/lmfb_back.sv =====
// Back end: buffer RAMs with row valid flags, pixel update, read reply, flush, clear.
// Depends on lmfb_pkg, lmfb_ram and the assertion macro header.
`include "led_matrix_framebuffer_flush_top_macros.svh"

module lmfb_back #(
   parameter int MAX_DEVICES = lmfb_pkg::DEFAULT_MAX_DEVICES,
   localparam int ROW_W = $clog2(MAX_DEVICES * lmfb_pkg::PIX_PER_ROW),
   localparam int DEV_W = $clog2(MAX_DEVICES + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  lmfb_pkg::lmfb_entry_type q_entry,
   input  logic [ROW_W-1:0]         q_row,
   output logic                     q_pop,
   input  logic [DEV_W-1:0]         active_devices,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_device_index,
   output logic [3:0]               rsp_row_register,
   output logic [7:0]               rsp_row_bits,
   output logic                     rsp_pixel_read,
   output logic                     rsp_is_read_reply,
   output logic                     rsp_last
);
   import lmfb_pkg::*;

   localparam int ROWS = MAX_DEVICES * PIX_PER_ROW;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WR2   = 3'd1;
   localparam logic [2:0] ST_RD2   = 3'd2;
   localparam logic [2:0] ST_FL_RD = 3'd3;
   localparam logic [2:0] ST_FL_EM = 3'd4;

   logic [2:0]       state_ff, state_in;
   lmfb_entry_type   ent_ff, ent_in;
   logic [ROW_W-1:0] row_ff, row_in, k_ff, k_in;
   logic [DEV_W-1:0] dev_ff, dev_in;
   logic [2:0]       rowc_ff, rowc_in;
   logic             vlat_ff, vlat_in, sel_hidden_ff, sel_hidden_in;
   logic [ROWS-1:0]  vis_valid_ff, vis_valid_in, hid_valid_ff, hid_valid_in;

   logic             ram_re, rd_hidden, ram_we, clr_vis, clr_hid;
   logic [ROW_W-1:0] ram_raddr, last_row;
   logic [DEV_W+2:0] row_total;
   logic [7:0]       ram_wdata, vis_rdata, hid_rdata, rdata, row_word;

   logic             load, out_free, load_last;
   logic [2:0]       load_dev;
   logic [3:0]       load_reg;
   logic [7:0]       load_bits;
   logic             load_pix, load_reply;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_device_index_ff;
   logic [3:0]       rsp_row_register_ff;
   logic [7:0]       rsp_row_bits_ff;
   logic             rsp_pixel_read_ff, rsp_is_read_reply_ff, rsp_last_ff;

   assign row_total = {active_devices, 3'b000} - 1'b1;
   assign last_row  = row_total[ROW_W-1:0];
   assign rdata     = sel_hidden_ff ? hid_rdata : vis_rdata;
   assign row_word  = vlat_ff ? rdata : 8'd0;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in   = state_ff;
      ent_in     = ent_ff;
      row_in     = row_ff;
      k_in       = k_ff;
      dev_in     = dev_ff;
      rowc_in    = rowc_ff;
      q_pop      = 1'b0;
      ram_re     = 1'b0;
      ram_raddr  = row_ff;
      rd_hidden  = 1'b0;
      ram_we     = 1'b0;
      ram_wdata  = row_word;
      clr_vis    = 1'b0;
      clr_hid    = 1'b0;
      load       = 1'b0;
      load_dev   = 3'd0;
      load_reg   = 4'd0;
      load_bits  = 8'd0;
      load_pix   = 1'b0;
      load_reply = 1'b0;
      load_last  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               ent_in = q_entry;
               row_in = q_row;
               case (q_entry.op)
                  KIND_WRITE: begin
                     ram_re    = 1'b1;
                     ram_raddr = q_row;
                     rd_hidden = q_entry.hidden;
                     state_in  = ST_WR2;
                  end
                  KIND_READ: begin
                     ram_re    = 1'b1;
                     ram_raddr = q_row;
                     rd_hidden = q_entry.hidden;
                     state_in  = ST_RD2;
                  end
                  KIND_FLUSH: begin
                     state_in = ST_FL_RD;
                  end
                  KIND_CLEAR: begin
                     clr_hid  = q_entry.hidden;
                     clr_vis  = !q_entry.hidden;
                     state_in = q_entry.with_flush ? ST_FL_RD : ST_IDLE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_WR2: begin
            ram_we = 1'b1;
            ram_wdata[PIX_MSB - ent_ff.bit_sel] = ent_ff.value;
            state_in = ST_IDLE;
         end
         ST_RD2: begin
            if (out_free) begin
               load       = 1'b1;
               load_pix   = ent_ff.hit && row_word[PIX_MSB - ent_ff.bit_sel];
               load_reply = 1'b1;
               load_last  = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_FL_RD: begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            k_in      = '0;
            dev_in    = active_devices;
            rowc_in   = 3'd0;
            state_in  = ST_FL_EM;
         end
         ST_FL_EM: begin
            if (out_free) begin
               load      = 1'b1;
               load_dev  = 3'(dev_ff - 1'b1);
               load_reg  = 4'({1'b0, rowc_ff}) + 4'd1;
               load_bits = row_word;
               load_last = (k_ff == last_row);
               if (k_ff == last_row) begin
                  state_in = ST_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = ROW_W'(k_ff + 1'b1);
                  k_in      = ROW_W'(k_ff + 1'b1);
                  if (dev_ff == DEV_W'(1)) begin
                     dev_in  = active_devices;
                     rowc_in = 3'(rowc_ff + 1'b1);
                  end else begin
                     dev_in = DEV_W'(dev_ff - 1'b1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      vlat_in       = vlat_ff;
      sel_hidden_in = sel_hidden_ff;
      if (ram_re) begin
         vlat_in       = rd_hidden ? hid_valid_ff[ram_raddr] : vis_valid_ff[ram_raddr];
         sel_hidden_in = rd_hidden;
      end
      vis_valid_in = clr_vis ? '0 : vis_valid_ff;
      hid_valid_in = clr_hid ? '0 : hid_valid_ff;
      if (ram_we && !ent_ff.hidden) begin
         vis_valid_in[row_ff] = 1'b1;
      end
      if (ram_we && ent_ff.hidden) begin
         hid_valid_in[row_ff] = 1'b1;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vis_valid_ff <= '0;
         hid_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vis_valid_ff <= vis_valid_in;
         hid_valid_ff <= hid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ent_ff        <= ent_in;
      row_ff        <= row_in;
      k_ff          <= k_in;
      dev_ff        <= dev_in;
      rowc_ff       <= rowc_in;
      vlat_ff       <= vlat_in;
      sel_hidden_ff <= sel_hidden_in;
      if (load) begin
         rsp_device_index_ff  <= load_dev;
         rsp_row_register_ff  <= load_reg;
         rsp_row_bits_ff      <= load_bits;
         rsp_pixel_read_ff    <= load_pix;
         rsp_is_read_reply_ff <= load_reply;
         rsp_last_ff          <= load_last;
      end
   end

   lmfb_ram #(.WIDTH(PIX_PER_ROW), .DEPTH(ROWS)) u_visible_ram (
      .clock      (clock),
      .write_en   (ram_we && !ent_ff.hidden),
      .write_addr (row_ff),
      .write_data (ram_wdata),
      .read_en    (ram_re && !rd_hidden),
      .read_addr  (ram_raddr),
      .read_data  (vis_rdata)
   );

   lmfb_ram #(.WIDTH(PIX_PER_ROW), .DEPTH(ROWS)) u_hidden_ram (
      .clock      (clock),
      .write_en   (ram_we && ent_ff.hidden),
      .write_addr (row_ff),
      .write_data (ram_wdata),
      .read_en    (ram_re && rd_hidden),
      .read_addr  (ram_raddr),
      .read_data  (hid_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_device_index  = rsp_device_index_ff;
   assign rsp_row_register  = rsp_row_register_ff;
   assign rsp_row_bits      = rsp_row_bits_ff;
   assign rsp_pixel_read    = rsp_pixel_read_ff;
   assign rsp_is_read_reply = rsp_is_read_reply_ff;
   assign rsp_last          = rsp_last_ff;

   `LMFB_ASSERT_IMP(a_pop_only_idle, q_pop, state_ff == ST_IDLE, "queue popped while busy")
   `LMFB_ASSERT_IMP(a_reply_is_last, rsp_valid && rsp_is_read_reply, rsp_last, "reply w/o last")
   `LMFB_ASSERT_NXT(a_flush_done, state_ff == ST_FL_EM && load_last, state_ff == ST_IDLE, "flush")
   `LMFB_ASSERT_IMP(a_write_after_read, ram_we, $past(ram_re), "row written without prior read")

endmodule

// ===== hdl/led_matrix_framebuffer_flush_top.sv =====
// Top level of the LED matrix frame store: front end, queue and back end.
// Depends on lmfb_pkg, lmfb_front, lmfb_queue and lmfb_back.
//
// Usage: items enter on req_* (valid/stall), results leave on rsp_* (valid/stall),
// registers are written through csr_write_enable/csr_index/csr_data while idle.
// The front end takes one item per cycle, while req_stall is low, into a two-entry
// queue and drops writes that fall outside the screen or clip window and flushes
// aimed at the hidden buffer. The back end takes one queued item at a time:
//   pixel write: row read, then merged row write to the buffer RAM;
//   pixel read : row read, then result loaded into the result register when free;
//   flush      : setup, then one row result per unstalled cycle, 8*M results;
//   clear      : valid flags cleared, plus the flush above when visible is target.
// A write occupies the back end for the read-modify-write of the 8-pixel row
// word in the row RAM. A read reply passes the queue, the row RAM read register
// and the result register; the queue lets the next items be accepted meanwhile.
// Reset: synchronous; per-row valid flags clear both buffers at once, no sweep.
// When rsp_stall is high while rsp_valid is set, the result register holds;
// reads and flushes in the back end wait, the queue fills and then req_stall rises.
module led_matrix_framebuffer_flush_top #(
   parameter int MAX_DEVICES = lmfb_pkg::DEFAULT_MAX_DEVICES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [lmfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lmfb_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_kind,
   input  logic [6:0]                       req_pos_x,
   input  logic [6:0]                       req_pos_y,
   input  logic                             req_pixel_on,
   input  logic                             req_read_hidden,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_device_index,
   output logic [3:0]                       rsp_row_register,
   output logic [7:0]                       rsp_row_bits,
   output logic                             rsp_pixel_read,
   output logic                             rsp_is_read_reply,
   output logic                             rsp_last
);
   import lmfb_pkg::*;

   localparam int ROW_W = $clog2(MAX_DEVICES * PIX_PER_ROW);
   localparam int DEV_W = $clog2(MAX_DEVICES + 1);
   localparam int ENT_W = $bits(lmfb_entry_type);
   localparam int Q_W   = ENT_W + ROW_W;

   logic             q_full, q_push, q_pop, q_not_empty;
   lmfb_entry_type   push_entry, head_entry;
   logic [ROW_W-1:0] push_row, head_row;
   logic [Q_W-1:0]   q_head;
   logic [DEV_W-1:0] active_devices;

   lmfb_front #(.MAX_DEVICES(MAX_DEVICES)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pixel_on     (req_pixel_on),
      .req_read_hidden  (req_read_hidden),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (push_entry),
      .q_row            (push_row),
      .active_devices   (active_devices)
   );

   lmfb_queue #(.DATA_W(Q_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_entry, push_row}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   assign head_entry = q_head[Q_W-1 -: ENT_W];
   assign head_row   = q_head[ROW_W-1:0];

   lmfb_back #(.MAX_DEVICES(MAX_DEVICES)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_not_empty),
      .q_entry           (head_entry),
      .q_row             (head_row),
      .q_pop             (q_pop),
      .active_devices    (active_devices),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_device_index  (rsp_device_index),
      .rsp_row_register  (rsp_row_register),
      .rsp_row_bits      (rsp_row_bits),
      .rsp_pixel_read    (rsp_pixel_read),
      .rsp_is_read_reply (rsp_is_read_reply),
      .rsp_last          (rsp_last)
   );

endmodule
